FILE: src/itf_pkg.sv
package itf_pkg;

  localparam int SectorWords = 256;
  localparam int PtrW = $clog2(SectorWords);
  localparam int SectorTicks = 256;
  localparam int ResetTicks = 2;
  localparam int CntW = 10;
  localparam int IdSteps = SectorWords;

  typedef enum logic [2:0] {
    OP_PORT_READ  = 3'd0,
    OP_PORT_WRITE = 3'd1,
    OP_TICK       = 3'd2,
    OP_LOAD       = 3'd3,
    OP_FETCH      = 3'd4,
    OP_DONE       = 3'd5,
    OP_NOP        = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_RESET = 2'd1,
    EV_READ  = 2'd2,
    EV_WRITE = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    MW_NONE  = 2'd0,
    MW_READ  = 2'd1,
    MW_WRITE = 2'd2
  } mw_e;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_RDWAIT = 3'd1,
    BK_IDENT  = 3'd2,
    BK_OUT    = 3'd3,
    BK_CLEAR  = 3'd4
  } bk_state_e;

  localparam logic [7:0] StErr   = 8'h01;
  localparam logic [7:0] StDrq   = 8'h08;
  localparam logic [7:0] StSeek  = 8'h10;
  localparam logic [7:0] StReady = 8'h40;
  localparam logic [7:0] StBusy  = 8'h80;

  localparam logic [7:0] CmdRead0  = 8'h20;
  localparam logic [7:0] CmdRead1  = 8'h21;
  localparam logic [7:0] CmdWrite0 = 8'h30;
  localparam logic [7:0] CmdWrite1 = 8'h31;
  localparam logic [7:0] CmdSetMul = 8'hc6;
  localparam logic [7:0] CmdIdent  = 8'hec;

  localparam logic [1:0] AddrCyl  = 2'd0;
  localparam logic [1:0] AddrHead = 2'd1;
  localparam logic [1:0] AddrSpt  = 2'd2;
  localparam logic [1:0] AddrRo   = 2'd3;

  typedef struct packed {
    op_e         op;
    logic [2:0]  port;
    logic [15:0] wdata;
    logic [7:0]  index;
    logic [15:0] mword;
    logic        ok;
  } item_t;

  // identify text: serial, firmware, model; pairs of characters per word
  function automatic logic [15:0] id_text(input logic [7:0] w);
    logic [15:0] t;
    t = 16'h2020;
    if (w >= 8'd10 && w <= 8'd14) t = 16'h3030;
    else if (w == 8'd23) t = 16'h312e;
    else if (w == 8'd24) t = 16'h3020;
    else if (w == 8'd27) t = 16'h4745;
    else if (w == 8'd28) t = 16'h4e45;
    else if (w == 8'd29) t = 16'h5249;
    else if (w == 8'd30) t = 16'h4320;
    else if (w == 8'd31) t = 16'h4154;
    else if (w == 8'd32) t = 16'h4120;
    else if (w == 8'd33) t = 16'h4449;
    else if (w == 8'd34) t = 16'h534b;
    return t;
  endfunction

endpackage

FILE: src/itf_front.sv
module itf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itf_pkg::item_t in_item_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output itf_pkg::item_t q_item_o
);
  import itf_pkg::*;

  // two-entry queue; opcodes beyond done are folded to a no-op
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t      cls;

  always_comb begin
    cls = in_item_i;
    if (in_item_i.op inside {3'd6, 3'd7}) cls.op = OP_NOP;
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (q_valid_o && q_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(q_valid_o && q_ready_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o) else $error("ready while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !q_valid_o) else $error("valid while empty");
endmodule

FILE: src/itf_back.sv
module itf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  itf_pkg::item_t q_item_i,
  input  logic [15:0]    cyl_i,
  input  logic [4:0]     heads_i,
  input  logic [7:0]     spt_i,
  input  logic           ro_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    read_data_o,
  output logic [1:0]     media_request_o,
  output logic [31:0]    media_lba_o,
  output logic [15:0]    media_word_out_o
);
  import itf_pkg::*;

  logic [15:0] buf_q [SectorWords];
  logic [15:0] rdat_q;
  logic        mem_we;
  logic [PtrW-1:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;

  logic [7:0]  st_q, st_d, err_q, err_d, head_q, head_d;
  logic [8:0]  left_q, left_d;
  logic [31:0] lba_q, lba_d;
  logic [PtrW:0] wp_q, wp_d;
  logic [CntW-1:0] cd_q, cd_d;
  ev_e  ev_q, ev_d;
  mw_e  mw_q, mw_d;
  bk_state_e state_q, state_d;
  logic [PtrW:0] id_q, id_d;
  logic        rdsel_q, rdsel_d;  // buffer read is a data-port read, not a fetch
  logic [15:0] rd_q, rd_d, wo_q, wo_d;
  logic [1:0]  req_q, req_d;
  logic [31:0] mlba_q, mlba_d;
  logic        valid_q, valid_d;
  logic        fetch_ok_q, fetch_ok_d;

  // identify geometry products, registered after each multiply
  logic [12:0] hs_q;
  logic [31:0] tot_q;
  always_ff @(posedge clk_i) begin
    hs_q  <= 13'(heads_i) * 13'(spt_i);
    tot_q <= cyl_i * 32'(hs_q);
  end

  function automatic logic [15:0] id_word(input logic [7:0] w, input logic [15:0] c,
                                          input logic [4:0] h, input logic [7:0] s,
                                          input logic [12:0] hs, input logic [31:0] t);
    logic [15:0] v;
    logic        hit;
    hit = 1'b1;
    v = 16'h0;
    case (w)
      8'd0:   v = 16'h045a;
      8'd1, 8'd54: v = c;
      8'd3, 8'd55: v = 16'(h);
      8'd6, 8'd56: v = 16'(s);
      8'd47:  v = 16'h8001;
      8'd49:  v = 16'h2f00;
      8'd53:  v = 16'd1;
      8'd57:  v = 16'(hs);
      8'd58:  v = 16'h0;
      8'd60, 8'd100: v = t[15:0];
      8'd61, 8'd101: v = t[31:16];
      default: begin
        if ((w >= 8'd10 && w <= 8'd19) || (w >= 8'd23 && w <= 8'd44)) v = id_text(w);
        else hit = 1'b0;
      end
    endcase
    return hit ? ~v : 16'hffff;
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) buf_q[mem_wa] <= mem_wd;
    rdat_q <= buf_q[mem_ra];
  end

  always_comb begin
    item_t it;
    logic [7:0] b;
    it = q_item_i;
    b = it.wdata[7:0];
    st_d = st_q; err_d = err_q; head_d = head_q; left_d = left_q; lba_d = lba_q;
    wp_d = wp_q; cd_d = cd_q; ev_d = ev_q; mw_d = mw_q; state_d = state_q;
    id_d = id_q; rdsel_d = rdsel_q; rd_d = rd_q; wo_d = wo_q; req_d = req_q;
    mlba_d = mlba_q; valid_d = valid_q; fetch_ok_d = fetch_ok_q;
    mem_we = 1'b0; mem_wa = wp_q[PtrW-1:0]; mem_wd = it.wdata;
    mem_ra = wp_q[PtrW-1:0];
    q_ready_o = 1'b0;
    if (valid_q && out_ready_i) valid_d = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && (!valid_q || out_ready_i)) begin
          q_ready_o = 1'b1;
          rd_d = 16'h0; req_d = 2'd0; mlba_d = 32'h0; wo_d = 16'h0;
          rdsel_d = 1'b0; valid_d = 1'b1;
          case (it.op)
            OP_PORT_READ: begin
              case (it.port)
                3'd0: begin
                  if (st_q[3]) begin
                    rdsel_d = 1'b1; fetch_ok_d = 1'b1;
                    valid_d = 1'b0; state_d = BK_RDWAIT;
                    wp_d = wp_q + 1'b1;
                    if (wp_q + 1'b1 >= (PtrW+1)'(SectorWords)) begin
                      wp_d = '0;
                      st_d = st_q & ~(StDrq | StBusy);
                      if (left_q != 9'd0) begin
                        st_d = (st_q & ~StDrq) | StBusy;
                        cd_d = CntW'(SectorTicks * 2);
                        ev_d = EV_READ;
                      end
                    end
                  end
                end
                3'd1: rd_d = {8'hff, err_q};
                3'd2: rd_d = {8'hff, left_q[7:0]};
                3'd3: rd_d = {8'hff, lba_q[7:0]};
                3'd4: rd_d = {8'hff, lba_q[15:8]};
                3'd5: rd_d = {8'hff, lba_q[23:16]};
                3'd6: rd_d = {8'hff, head_q};
                default: rd_d = {8'hff, st_q};
              endcase
            end
            OP_PORT_WRITE: begin
              case (it.port)
                3'd0: begin
                  if (st_q[3]) begin
                    mem_we = 1'b1;
                    wp_d = wp_q + 1'b1;
                    if (wp_q + 1'b1 >= (PtrW+1)'(SectorWords)) begin
                      wp_d = '0;
                      st_d = (st_q & ~StDrq) | StBusy;
                      cd_d = CntW'(SectorTicks);
                      ev_d = EV_WRITE;
                    end
                  end
                end
                3'd1: ;
                3'd2: left_d = (b == 8'd0) ? 9'd256 : {1'b0, b};
                3'd3: lba_d[7:0] = b;
                3'd4: lba_d[15:8] = b;
                3'd5: lba_d[23:16] = b;
                3'd6: head_d = b;
                default: begin
                  case (b)
                    CmdRead0, CmdRead1: begin
                      st_d = (st_q | StBusy) & ~StDrq;
                      cd_d = CntW'(SectorTicks * 3);
                      ev_d = EV_READ;
                    end
                    CmdWrite0, CmdWrite1: begin
                      wp_d = '0; st_d = st_q | StDrq;
                    end
                    CmdSetMul: st_d = st_q | StDrq;
                    CmdIdent: begin
                      wp_d = '0; left_d = 9'd1;
                      st_d = (st_q | StDrq | StSeek | StReady) & ~(StBusy | StErr);
                      id_d = '0; valid_d = 1'b0; state_d = BK_IDENT;
                    end
                    default: ;
                  endcase
                end
              endcase
            end
            OP_TICK: begin
              if (cd_q != '0) begin
                cd_d = cd_q - 1'b1;
                if (cd_q == CntW'(1)) begin
                  ev_d = EV_NONE;
                  case (ev_q)
                    EV_RESET: st_d = (st_q & ~StBusy) | StReady | StSeek;
                    EV_READ: begin
                      req_d = 2'd1; mlba_d = lba_q; mw_d = MW_READ;
                    end
                    EV_WRITE: begin
                      if (ro_i) begin
                        st_d = (st_q & ~(StBusy | StErr)) | StDrq | StSeek | StErr;
                        err_d = 8'h80;
                      end else begin
                        req_d = 2'd2; mlba_d = lba_q; mw_d = MW_WRITE;
                      end
                    end
                    default: ;
                  endcase
                end
              end
            end
            OP_LOAD: begin
              if (mw_q == MW_READ && 32'(it.index) < SectorWords) begin
                mem_we = 1'b1; mem_wa = PtrW'(it.index); mem_wd = it.mword;
              end
            end
            OP_FETCH: begin
              mem_ra = PtrW'(it.index);
              rdsel_d = 1'b0; fetch_ok_d = 32'(it.index) < SectorWords;
              valid_d = 1'b0; state_d = BK_RDWAIT;
            end
            OP_DONE: begin
              if (mw_q != MW_NONE) begin
                mw_d = MW_NONE;
                st_d = (st_q & ~(StBusy | StErr)) | StDrq | StSeek;
                if (!it.ok) begin
                  st_d = st_d | StErr; err_d = 8'h80;
                end else begin
                  if (left_q != 9'd0) left_d = left_q - 1'b1;
                  if (left_q > 9'd1) lba_d = lba_q + 32'd1;
                  err_d = 8'h0; wp_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_RDWAIT: begin
        // registered buffer data arrives now; data-port reads go to read_data
        if (rdsel_q) rd_d = rdat_q;
        else wo_d = fetch_ok_q ? rdat_q : 16'h0;
        valid_d = 1'b1;
        state_d = BK_IDLE;
      end
      BK_IDENT: begin
        mem_we = 1'b1;
        mem_wa = id_q[PtrW-1:0];
        mem_wd = id_word(8'(id_q), cyl_i, heads_i, spt_i, hs_q, tot_q);
        id_d = id_q + 1'b1;
        if (id_q == (PtrW+1)'(IdSteps - 1)) begin
          valid_d = 1'b1; state_d = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        // zero one buffer word per cycle after reset
        mem_we = 1'b1;
        mem_wa = id_q[PtrW-1:0];
        mem_wd = 16'h0;
        id_d = id_q + 1'b1;
        if (id_q == (PtrW+1)'(SectorWords - 1)) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StBusy; err_q <= '0; head_q <= '0; left_q <= '0; lba_q <= '0;
      wp_q <= '0; cd_q <= CntW'(ResetTicks); ev_q <= EV_RESET; mw_q <= MW_NONE;
      state_q <= BK_CLEAR; id_q <= '0; valid_q <= 1'b0;
    end else begin
      st_q <= st_d; err_q <= err_d; head_q <= head_d; left_q <= left_d; lba_q <= lba_d;
      wp_q <= wp_d; cd_q <= cd_d; ev_q <= ev_d; mw_q <= mw_d;
      state_q <= state_d; id_q <= id_d; valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdsel_q <= rdsel_d; rd_q <= rd_d; wo_q <= wo_d; req_q <= req_d;
    mlba_q <= mlba_d; fetch_ok_q <= fetch_ok_d;
  end

  assign out_valid_o      = valid_q;
  assign read_data_o      = rd_q;
  assign media_request_o  = req_q;
  assign media_lba_o      = mlba_q;
  assign media_word_out_o = wo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (req_q != 2'd3)) else $error("bad media request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE) |-> !q_ready_o) else $error("item taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> valid_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q != 2'd0 && valid_q) |-> (mw_q != MW_NONE)) else $error("request without wait");
endmodule

FILE: src/ide_task_file_disk_device.sv
// ATA task-file disk device with a host port window and a media side.
// Input channel (in_valid_i/in_ready_o): one item per opcode: port read,
// port write, timer tick, media load word, media fetch word, media done.
// Output channel (out_valid_o/out_ready_i): exactly one result per item with
// read_data, media_request, media_lba and media_word_out.
// Items enter a two-entry queue and are executed one at a time by the back
// end. Data-port reads with DRQ set and media fetches pass through a wait
// state (the buffer RAM read is registered), and identify writes one buffer
// word per cycle before its result is offered. Results are registered.
// Geometry registers are written over the APB port at byte addresses
// 0, 4, 8, 12 (cylinders, heads, sectors per track, read only).
// After reset the back end clears the sector buffer word by word before it
// takes the first item, and the device reports busy until two ticks have been
// seen. When the receiver stalls the result is held and the queue keeps
// taking items until it fills.
module ide_task_file_disk_device (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [2:0]  port_i,
  input  logic [15:0] write_data_i,
  input  logic [7:0]  media_index_i,
  input  logic [15:0] media_word_i,
  input  logic        media_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic [1:0]  media_request_o,
  output logic [31:0] media_lba_o,
  output logic [15:0] media_word_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import itf_pkg::*;

  item_t       in_item, q_item;
  logic        q_valid, q_ready;
  logic [15:0] cyl_q;
  logic [4:0]  heads_q;
  logic [7:0]  spt_q;
  logic        ro_q;

  assign in_item = '{op: op_e'(opcode_i), port: port_i, wdata: write_data_i,
                     index: media_index_i, mword: media_word_i, ok: media_ok_i};

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyl_q <= 16'd256; heads_q <= 5'd16; spt_q <= 8'd255; ro_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        AddrCyl:  cyl_q <= pwdata[15:0];
        AddrHead: heads_q <= pwdata[4:0];
        AddrSpt:  spt_q <= pwdata[7:0];
        AddrRo:   ro_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      AddrCyl:  prdata = {16'h0, cyl_q};
      AddrHead: prdata = {27'h0, heads_q};
      AddrSpt:  prdata = {24'h0, spt_q};
      AddrRo:   prdata = {31'h0, ro_q};
      default:  prdata = 32'h0;
    endcase
  end

  itf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  itf_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .cyl_i(cyl_q), .heads_i(heads_q), .spt_i(spt_q), .ro_i(ro_q),
    .out_valid_o, .out_ready_i, .read_data_o, .media_request_o, .media_lba_o,
    .media_word_out_o
  );
endmodule

FILE: bench/ide_task_file_checker.sv
`timescale 1ns / 1ps

package tb_port_pkg;
  localparam logic [2:0] PortData  = 3'd0;
  localparam logic [2:0] PortError = 3'd1;
  localparam logic [2:0] PortCount = 3'd2;
  localparam logic [2:0] PortLba0  = 3'd3;
  localparam logic [2:0] PortLba1  = 3'd4;
  localparam logic [2:0] PortLba2  = 3'd5;
  localparam logic [2:0] PortHead  = 3'd6;
  localparam logic [2:0] PortCmd   = 3'd7;
endpackage

module ide_task_file_checker
  import itf_pkg::*;
  import tb_port_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [2:0]  port_i,
  input  logic [15:0] write_data_i,
  input  logic [7:0]  media_index_i,
  input  logic [15:0] media_word_i,
  input  logic        media_ok_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] read_data_i,
  input  logic [1:0]  media_request_i,
  input  logic [31:0] media_lba_i,
  input  logic [15:0] media_word_out_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          failures_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [15:0] rdata;
    logic [1:0]  req;
    logic [31:0] lba;
    logic [15:0] wout;
  } device_result_t;

  device_result_t result_queue[$];

  // shadow of the geometry registers and the task file
  logic [15:0] cyl_q;
  logic [4:0]  heads_q;
  logic [7:0]  spt_q;
  logic        ro_q;
  logic [7:0]  status_q, error_q, head_reg_q;
  logic [8:0]  left_q, wptr_q;
  logic [31:0] addr_q;
  logic [9:0]  timer_q;
  ev_e         event_q;
  mw_e         wait_q;
  logic [15:0] sector_mem[SectorWords];

  function automatic void put_word(input int idx, input logic [15:0] val);
    sector_mem[idx] = ~val;
  endfunction

  function automatic void put_text(input int start, input string s, input int words);
    logic [7:0] hi, lo;
    for (int k = 0; k < words; k++) begin
      hi = (2 * k < s.len()) ? s[2 * k] : 8'h20;
      lo = (2 * k + 1 < s.len()) ? s[2 * k + 1] : 8'h20;
      put_word(start + k, {hi, lo});
    end
  endfunction

  function automatic void build_identify();
    logic [31:0] hs, total;
    hs = heads_q * spt_q;
    total = cyl_q * hs;
    for (int i = 0; i < SectorWords; i++) sector_mem[i] = 16'hffff;
    put_word(0, 16'h045a);
    put_word(1, cyl_q);
    put_word(3, heads_q);
    put_word(6, spt_q);
    put_text(10, "0000000000", 10);
    put_text(23, "1.0", 4);
    put_text(27, "GENERIC ATA DISK", 18);
    put_word(47, 16'h8001);
    put_word(49, 16'h2f00);
    put_word(53, 16'd1);
    put_word(54, cyl_q);
    put_word(55, heads_q);
    put_word(56, spt_q);
    put_word(57, hs[15:0]);
    put_word(58, hs[31:16]);
    put_word(60, total[15:0]);
    put_word(61, total[31:16]);
    put_word(100, total[15:0]);
    put_word(101, total[31:16]);
  endfunction

  function automatic void end_sector(input logic ok);
    status_q = (status_q & ~(StBusy | StErr)) | StDrq | StSeek;
    if (!ok) begin
      status_q |= StErr;
      error_q = 8'h80;
      return;
    end
    if (left_q > 0) left_q--;
    if (left_q > 0) addr_q++;
    error_q = 8'h00;
    wptr_q = '0;
  endfunction

  function automatic void run_command(input logic [7:0] cmd);
    case (cmd)
      CmdRead0, CmdRead1: begin
        status_q = (status_q | StBusy) & ~StDrq;
        timer_q = SectorTicks * 3;
        event_q = EV_READ;
      end
      CmdWrite0, CmdWrite1: begin
        wptr_q = '0;
        status_q |= StDrq;
      end
      CmdSetMul: status_q |= StDrq;
      CmdIdent: begin
        build_identify();
        wptr_q = '0;
        left_q = 9'd1;
        status_q = (status_q | StDrq | StSeek | StReady) & ~(StBusy | StErr);
      end
      default: ;
    endcase
  endfunction

  function automatic device_result_t predict_result(input logic [2:0] op, input logic [2:0] port,
                                                    input logic [15:0] wd, input logic [7:0] idx,
                                                    input logic [15:0] mw, input logic ok);
    device_result_t r;
    ev_e fired;
    r = '0;
    case (op)
      OP_PORT_READ: begin
        case (port)
          PortData: begin
            if (status_q & StDrq) begin
              r.rdata = sector_mem[wptr_q[7:0]];
              wptr_q++;
              if (wptr_q >= SectorWords) begin
                wptr_q = '0;
                status_q &= ~(StDrq | StBusy);
                if (left_q > 0) begin
                  status_q |= StBusy;
                  timer_q = SectorTicks * 2;
                  event_q = EV_READ;
                end
              end
            end
          end
          PortError: r.rdata = {8'hff, error_q};
          PortCount: r.rdata = {8'hff, left_q[7:0]};
          PortLba0:  r.rdata = {8'hff, addr_q[7:0]};
          PortLba1:  r.rdata = {8'hff, addr_q[15:8]};
          PortLba2:  r.rdata = {8'hff, addr_q[23:16]};
          PortHead:  r.rdata = {8'hff, head_reg_q};
          default:   r.rdata = {8'hff, status_q};
        endcase
      end
      OP_PORT_WRITE: begin
        case (port)
          PortData: begin
            if (status_q & StDrq) begin
              sector_mem[wptr_q[7:0]] = wd;
              wptr_q++;
              if (wptr_q >= SectorWords) begin
                wptr_q = '0;
                status_q = (status_q & ~StDrq) | StBusy;
                timer_q = SectorTicks;
                event_q = EV_WRITE;
              end
            end
          end
          PortError: ;
          PortCount: left_q = (wd[7:0] == 8'd0) ? 9'd256 : {1'b0, wd[7:0]};
          PortLba0:  addr_q[7:0] = wd[7:0];
          PortLba1:  addr_q[15:8] = wd[7:0];
          PortLba2:  addr_q[23:16] = wd[7:0];
          PortHead:  head_reg_q = wd[7:0];
          default:   run_command(wd[7:0]);
        endcase
      end
      OP_TICK: begin
        if (timer_q != 0) begin
          timer_q--;
          if (timer_q == 0) begin
            fired = event_q;
            event_q = EV_NONE;
            case (fired)
              EV_RESET: status_q = (status_q & ~StBusy) | StReady | StSeek;
              EV_READ: begin
                r.req = 2'd1;
                r.lba = addr_q;
                wait_q = MW_READ;
              end
              EV_WRITE: begin
                if (ro_q) begin
                  status_q &= ~StBusy;
                  end_sector(1'b0);
                end else begin
                  r.req = 2'd2;
                  r.lba = addr_q;
                  wait_q = MW_WRITE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_LOAD: if (wait_q == MW_READ) sector_mem[idx] = mw;
      OP_FETCH: r.wout = sector_mem[idx];
      OP_DONE: begin
        if (wait_q != MW_NONE) begin
          wait_q = MW_NONE;
          end_sector(ok);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign outstanding_o = result_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    device_result_t want, got;
    if (!rst_ni) begin
      cyl_q = 16'd256;
      heads_q = 5'd16;
      spt_q = 8'd255;
      ro_q = 1'b0;
      status_q = StBusy;
      error_q = '0;
      left_q = '0;
      addr_q = '0;
      head_reg_q = '0;
      wptr_q = '0;
      timer_q = ResetTicks;
      event_q = EV_RESET;
      wait_q = MW_NONE;
      for (int i = 0; i < SectorWords; i++) sector_mem[i] = '0;
      result_queue.delete();
      failures_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{read_data_i, media_request_i, media_lba_i, media_word_out_i};
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failures_o++;
        end else begin
          want = result_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch rdata exp %h got %h, req exp %0d got %0d, lba exp %h got %h, wout exp %h got %h",
                     $time, want.rdata, got.rdata, want.req, got.req,
                     want.lba, got.lba, want.wout, got.wout);
            failures_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        result_queue.push_back(predict_result(opcode_i, port_i, write_data_i,
                                              media_index_i, media_word_i, media_ok_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          AddrCyl:  cyl_q = pwdata_i[15:0];
          AddrHead: heads_q = pwdata_i[4:0];
          AddrSpt:  spt_q = pwdata_i[7:0];
          default:  ro_q = pwdata_i[0];
        endcase
      end
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import itf_pkg::*;
  import tb_port_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 300;
  localparam int PhaseOneItems = 100;
  localparam int PhaseTwoItems = 120;
  localparam int PhaseThreeItems = 100;
  localparam int ReadItems = 1070;
  localparam int WriteItems = 530;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0, in_ready;
  logic [2:0]  opcode = '0, port = '0;
  logic [15:0] write_data = '0, media_word = '0;
  logic [7:0]  media_index = '0;
  logic        media_ok = 1'b0;
  logic        out_valid, out_ready = 1'b0;
  logic [15:0] read_data, media_word_out;
  logic [1:0]  media_request;
  logic [31:0] media_lba;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int          failures, outstanding;
  int          send_idle = 35, recv_idle = 72;
  int          items_sent = 0;
  int          cycles = 0;
  bit          hold_req = 1'b0;

  always #2 clk = ~clk;

  ide_task_file_disk_device dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .port_i(port), .write_data_i(write_data),
    .media_index_i(media_index), .media_word_i(media_word), .media_ok_i(media_ok),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .read_data_o(read_data), .media_request_o(media_request),
    .media_lba_o(media_lba), .media_word_out_o(media_word_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ide_task_file_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .port_i(port), .write_data_i(write_data),
    .media_index_i(media_index), .media_word_i(media_word), .media_ok_i(media_ok),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .read_data_i(read_data), .media_request_i(media_request),
    .media_lba_i(media_lba), .media_word_out_i(media_word_out),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .failures_o(failures), .outstanding_o(outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("** ide_task_file_disk_device: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to fill the queue
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(input op_e op, input logic [2:0] p, input logic [15:0] wd,
                      input logic [7:0] idx, input logic [15:0] mw, input logic ok);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    port <= p;
    write_data <= wd;
    media_index <= idx;
    media_word <= mw;
    media_ok <= ok;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic port_wr(input logic [2:0] p, input logic [15:0] wd);
    send(OP_PORT_WRITE, p, wd, $urandom, $urandom, $urandom);
  endtask

  task automatic port_rd(input logic [2:0] p);
    send(OP_PORT_READ, p, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic tick(input int n);
    repeat (n) send(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic media_done(input logic ok);
    send(OP_DONE, $urandom, $urandom, $urandom, $urandom, ok);
  endtask

  task automatic fetch(input logic [7:0] idx);
    send(OP_FETCH, $urandom, $urandom, idx, $urandom, $urandom);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold until the device is quiet, identify included
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [15:0] c, input logic [4:0] h,
                              input logic [7:0] s, input logic ro);
    reg_write(AddrCyl, c);
    reg_write(AddrHead, h);
    reg_write(AddrSpt, s);
    reg_write(AddrRo, ro);
  endtask

  task automatic read_sector();
    port_wr(PortCount, $urandom_range(1, 2));
    port_wr(PortLba0, $urandom);
    port_wr(PortLba1, $urandom);
    port_wr(PortLba2, $urandom);
    port_wr(PortCmd, $urandom_range(1) ? CmdRead0 : CmdRead1);
    tick(SectorTicks * 3);
    repeat ($urandom_range(4, 12))
      send(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
    port_rd(PortCmd);
    media_done($urandom_range(9) != 0);
    repeat (SectorWords) begin
      if ($urandom_range(19) == 0) port_rd($urandom_range(1, 7));
      port_rd(PortData);
    end
  endtask

  task automatic write_sector();
    port_wr(PortCount, $urandom_range(1, 3));
    port_wr(PortLba0, $urandom);
    port_wr(PortCmd, $urandom_range(1) ? CmdWrite0 : CmdWrite1);
    repeat (SectorWords) port_wr(PortData, $urandom);
    tick(SectorTicks);
    repeat ($urandom_range(2, 6)) fetch($urandom);
    media_done($urandom_range(9) != 0);
    port_rd(PortError);
    port_rd(PortCmd);
  endtask

  task automatic noise(input int n);
    repeat (n)
      send(op_e'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // sector transfers only where they fit in what is left of the phase
  task automatic random_phase(input int budget);
    int start;
    int room;
    start = items_sent;
    while (items_sent - start < budget) begin
      room = budget - (items_sent - start);
      case ($urandom_range(5))
        0, 1: if (room >= ReadItems) read_sector(); else noise(20);
        2: if (room >= WriteItems) write_sector(); else noise(20);
        3: begin
          port_wr(PortCmd, CmdIdent);
          repeat (8) fetch($urandom);
          repeat ($urandom_range(5, 40)) port_rd(PortData);
        end
        4: begin
          port_wr(PortCmd, CmdSetMul);
          port_wr(PortHead, $urandom);
          port_rd(PortHead);
          port_wr(PortCount, 16'h0000);
          port_rd(PortCount);
        end
        default: noise(20);
      endcase
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    set_geometry(16'd65535, 5'd16, 8'd255, 1'b0);

    // directed: reset timer, idle reads, out-of-turn media items, identify, register writes
    for (int p = 1; p < 8; p++) port_rd(3'(p));
    media_done(1'b1);
    send(OP_LOAD, 3'd0, 16'hffff, 8'hff, 16'hffff, 1'b1);
    tick(ResetTicks);
    port_rd(PortCmd);
    send(OP_NOP, 3'd7, 16'hffff, 8'hff, 16'hffff, 1'b1);
    send(op_e'(3'd7), 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b0);
    port_wr(PortCmd, 16'hff00);
    port_wr(PortCmd, CmdIdent);
    fetch(8'd0);
    fetch(8'd27);
    fetch(8'd100);
    fetch(8'd255);
    port_rd(PortData);
    port_rd(PortData);
    port_wr(PortCount, 16'hff00);
    port_rd(PortCount);
    port_wr(PortLba2, 16'h00ff);
    port_rd(PortLba2);
    port_wr(PortError, 16'hffff);
    port_wr(PortCmd, CmdSetMul);
    port_rd(PortError);

    read_sector();
    random_phase(PhaseOneItems);
    drain();
    set_geometry(16'd1, 5'd1, 8'd1, 1'b1);
    send_idle = 72;
    recv_idle = 35;
    port_wr(PortCmd, CmdIdent);
    repeat (4) fetch($urandom);
    random_phase(PhaseTwoItems);
    drain();
    set_geometry($urandom_range(1, 65535), $urandom_range(1, 16), $urandom_range(1, 255),
                 $urandom_range(1));
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    write_sector();
    random_phase(PhaseThreeItems);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (failures == 0)
      $display("** ide_task_file_disk_device: PASSED **");
    else
      $display("** ide_task_file_disk_device: FAILED **");
    $finish;
  end

endmodule
